// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Types, codes and sizes shared by the bounded double-ended queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_REAR  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_REAR   = 3'd3,
		FN_DUMP       = 3'd4
	} func_e_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic        [2:0]  func;
		logic signed [31:0] item_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] data_value;
		logic        [1:0]  status;
		logic               last;
	} res_item_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH_FRONT,
		OP_PUSH_REAR,
		OP_POP_FRONT,
		OP_POP_REAR,
		OP_DUMP_FIRST,
		OP_DUMP_NEXT
	} op_t;

	typedef enum logic [1:0] {
		OUT_HOLD,
		OUT_STATUS,
		OUT_DATA
	} out_sel_t;

	typedef struct packed {
		op_t      op;
		out_sel_t out_sel;
		status_t  status;
		logic     last;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic dump_last;
	} dp_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_POP,
		S_RD_DUMP,
		S_OUT_LAST,
		S_OUT_MORE
	} state_t;

endpackage

`default_nettype wire

// ===== design/bounded_deque_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed 32-bit items.
// ----------------------------------------------------------------------------
// The queue holds up to bdq_pkg::DEPTH items in a circular store and takes
// one command at a time: push front, push rear, pop front, pop rear or dump.
// A push, a full push or a pop or dump on an empty queue presents its single
// result in the cycle after the transfer. A pop presents the item after it
// passes the store's read register and the result register. A dump of N
// items presents N results, each read the same way once the previous one
// was taken, and marks the final one with last. The next command is taken
// in the cycle after the final result has been taken. The store needs no
// clearing after reset. Unused function codes are absorbed with no result.
`default_nettype none

module bounded_deque_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire bdq_pkg::cmd_item_t  cmd_data,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output bdq_pkg::res_item_t       res_data
);

	bdq_pkg::dp_cmd_t dp_cmd;
	bdq_pkg::dp_sts_t dp_sts;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.func     (cmd_data.func),
		.res_stall(res_stall),
		.sts      (dp_sts),
		.cmd_stall(cmd_stall),
		.res_valid(res_valid),
		.cmd      (dp_cmd)
	);

	bdq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (dp_cmd),
		.item_value(cmd_data.item_value),
		.sts       (dp_sts),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire

// ===== design/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// Front index, item count, dump offset, entry store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bdq_pkg::dp_cmd_t   cmd,
	input  wire logic signed [31:0] item_value,
	output bdq_pkg::dp_sts_t        sts,
	output bdq_pkg::res_item_t      res_data
);

	localparam int IW = bdq_pkg::IDX_W;
	localparam int CW = bdq_pkg::CNT_W;

	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] off_q;
	bdq_pkg::res_item_t res_q;

	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [CW-1:0] off_next;
	logic          we;
	logic [IW-1:0] waddr;
	logic          re;
	logic [IW-1:0] raddr;
	logic [31:0]   rdata;

	function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(bdq_pkg::DEPTH)) begin
			sum = sum - (CW+1)'(bdq_pkg::DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign front_dec = (front_q == '0) ? IW'(bdq_pkg::DEPTH - 1) : front_q - IW'(1);
	assign front_inc = (front_q == IW'(bdq_pkg::DEPTH - 1)) ? '0 : front_q + IW'(1);
	assign off_next  = CW'(off_q) + CW'(1);

	always_comb begin
		we    = 1'b0;
		waddr = front_q;
		re    = 1'b0;
		raddr = front_q;
		unique case (cmd.op)
			bdq_pkg::OP_PUSH_FRONT: begin
				we    = 1'b1;
				waddr = front_dec;
			end
			bdq_pkg::OP_PUSH_REAR: begin
				we    = 1'b1;
				waddr = slot(front_q, count_q);
			end
			bdq_pkg::OP_POP_FRONT: begin
				re    = 1'b1;
				raddr = front_q;
			end
			bdq_pkg::OP_POP_REAR: begin
				re    = 1'b1;
				raddr = slot(front_q, count_q - CW'(1));
			end
			bdq_pkg::OP_DUMP_FIRST: begin
				re    = 1'b1;
				raddr = front_q;
			end
			bdq_pkg::OP_DUMP_NEXT: begin
				re    = 1'b1;
				raddr = slot(front_q, off_next);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			off_q   <= '0;
		end else begin
			unique case (cmd.op)
				bdq_pkg::OP_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + CW'(1);
				end
				bdq_pkg::OP_PUSH_REAR: begin
					count_q <= count_q + CW'(1);
				end
				bdq_pkg::OP_POP_FRONT: begin
					front_q <= front_inc;
					count_q <= count_q - CW'(1);
				end
				bdq_pkg::OP_POP_REAR: begin
					count_q <= count_q - CW'(1);
				end
				bdq_pkg::OP_DUMP_FIRST: begin
					off_q <= '0;
				end
				bdq_pkg::OP_DUMP_NEXT: begin
					off_q <= off_next[IW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.out_sel)
			bdq_pkg::OUT_STATUS: begin
				res_q.data_value <= '0;
				res_q.status     <= cmd.status;
				res_q.last       <= 1'b1;
			end
			bdq_pkg::OUT_DATA: begin
				res_q.data_value <= rdata;
				res_q.status     <= bdq_pkg::STS_OK;
				res_q.last       <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	bdq_ram #(
		.WIDTH(32),
		.DEPTH(bdq_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(item_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(bdq_pkg::DEPTH));
	assign sts.dump_last = (off_next == count_q);
	assign res_data      = res_q;

endmodule

`default_nettype wire

// ===== design/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Operation sequencer: decodes a command, steps reads and hands off results.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire logic [2:0]       func,
	input  wire logic             res_stall,
	input  wire bdq_pkg::dp_sts_t sts,
	output logic                  cmd_stall,
	output logic                  res_valid,
	output bdq_pkg::dp_cmd_t      cmd
);

	bdq_pkg::state_t state_q;
	bdq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.op      = bdq_pkg::OP_NONE;
		cmd.out_sel = bdq_pkg::OUT_HOLD;
		cmd.status  = bdq_pkg::STS_OK;
		cmd.last    = 1'b1;
		cmd_stall   = 1'b1;
		res_valid   = 1'b0;
		unique case (state_q)
			bdq_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					priority if (func == bdq_pkg::FN_PUSH_FRONT ||
							func == bdq_pkg::FN_PUSH_REAR) begin
						cmd.out_sel = bdq_pkg::OUT_STATUS;
						state_d     = bdq_pkg::S_OUT_LAST;
						if (sts.full) begin
							cmd.status = bdq_pkg::STS_FULL;
						end else if (func == bdq_pkg::FN_PUSH_FRONT) begin
							cmd.op = bdq_pkg::OP_PUSH_FRONT;
						end else begin
							cmd.op = bdq_pkg::OP_PUSH_REAR;
						end
					end else if (func == bdq_pkg::FN_POP_FRONT ||
							func == bdq_pkg::FN_POP_REAR ||
							func == bdq_pkg::FN_DUMP) begin
						if (sts.empty) begin
							cmd.out_sel = bdq_pkg::OUT_STATUS;
							cmd.status  = bdq_pkg::STS_EMPTY;
							state_d     = bdq_pkg::S_OUT_LAST;
						end else if (func == bdq_pkg::FN_POP_FRONT) begin
							cmd.op  = bdq_pkg::OP_POP_FRONT;
							state_d = bdq_pkg::S_RD_POP;
						end else if (func == bdq_pkg::FN_POP_REAR) begin
							cmd.op  = bdq_pkg::OP_POP_REAR;
							state_d = bdq_pkg::S_RD_POP;
						end else begin
							cmd.op  = bdq_pkg::OP_DUMP_FIRST;
							state_d = bdq_pkg::S_RD_DUMP;
						end
					end else begin
						state_d = bdq_pkg::S_IDLE;
					end
				end
			end
			bdq_pkg::S_RD_POP: begin
				cmd.out_sel = bdq_pkg::OUT_DATA;
				cmd.last    = 1'b1;
				state_d     = bdq_pkg::S_OUT_LAST;
			end
			bdq_pkg::S_RD_DUMP: begin
				cmd.out_sel = bdq_pkg::OUT_DATA;
				cmd.last    = sts.dump_last;
				state_d     = sts.dump_last ? bdq_pkg::S_OUT_LAST : bdq_pkg::S_OUT_MORE;
			end
			bdq_pkg::S_OUT_LAST: begin
				res_valid = 1'b1;
				if (!res_stall) begin
					state_d = bdq_pkg::S_IDLE;
				end
			end
			bdq_pkg::S_OUT_MORE: begin
				res_valid = 1'b1;
				if (!res_stall) begin
					cmd.op  = bdq_pkg::OP_DUMP_NEXT;
					state_d = bdq_pkg::S_RD_DUMP;
				end
			end
			default: begin
				state_d = bdq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/bdq_checker.sv =====
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the bounded double-ended queue, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               cmd_valid,
	input wire logic               cmd_stall,
	input wire bdq_pkg::cmd_item_t cmd_data,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire bdq_pkg::res_item_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("Stalled result changed or was withdrawn.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cmd_stall)
		else $error("Command taken while a result is pending.");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (cmd_data.func == bdq_pkg::FN_PUSH_FRONT ||
			cmd_data.func == bdq_pkg::FN_PUSH_REAR ||
			cmd_data.func == bdq_pkg::FN_POP_FRONT ||
			cmd_data.func == bdq_pkg::FN_POP_REAR ||
			cmd_data.func == bdq_pkg::FN_DUMP) |=> cmd_stall)
		else $error("Command transfer did not start an operation.");

	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != bdq_pkg::STS_OK |->
			res_data.data_value == 0 && res_data.last)
		else $error("Error result carries data or is not final.");

endmodule

bind bounded_deque_top bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd_data (cmd_data),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

`default_nettype wire
